// File: rtl/core/hkm_pkg.sv
// ----------------------------------------------------------------------------
// hkm_pkg
// Shared types, constants and helpers of the histogram k-means segmenter.
// ----------------------------------------------------------------------------
package hkm_pkg;

    localparam int MAX_CLASSES = 8;
    localparam int LEVELS      = 256;
    localparam int COUNT_WIDTH = 24;

    localparam int LVL_W   = 8;     // gray level
    localparam int CLS_W   = 3;     // cluster index
    localparam int LABEL_W = 4;     // 1-based label / class count
    localparam int MEAN_W  = 18;    // signed 10.8 mean, may dip below zero
    localparam int OUT_W   = 16;    // unsigned 8.8 mean on the port
    localparam int SUM_W   = 40;    // weighted sum of one cluster
    localparam int TOT_W   = 32;    // pixel count of one cluster
    localparam int DVD_W   = 49;    // divider dividend
    localparam int DVS_W   = 33;    // divider divisor
    localparam int STEP_W  = 6;     // divider step counter

    localparam logic CFG_NUM_CLASSES = 1'b0;
    localparam logic CFG_MAX_ITER    = 1'b1;

    localparam logic CMD_LOAD     = 1'b0;
    localparam logic CMD_CLASSIFY = 1'b1;

    localparam logic KIND_MEAN  = 1'b0;
    localparam logic KIND_LABEL = 1'b1;

    typedef logic [MAX_CLASSES-1:0][MEAN_W-1:0] mean_arr_t;

    typedef enum logic [14:0] {
        ST_CLR       = 15'b000000000000001,
        ST_IDLE      = 15'b000000000000010,
        ST_LD_RD     = 15'b000000000000100,
        ST_LD_WR     = 15'b000000000001000,
        ST_CLS       = 15'b000000000010000,
        ST_INIT_GO   = 15'b000000000100000,
        ST_INIT_WAIT = 15'b000000001000000,
        ST_ITER      = 15'b000000010000000,
        ST_PASS      = 15'b000000100000000,
        ST_DRAIN     = 15'b000001000000000,
        ST_RECALC    = 15'b000010000000000,
        ST_DIV_WAIT  = 15'b000100000000000,
        ST_CHECK     = 15'b001000000000000,
        ST_CLAMP     = 15'b010000000000000,
        ST_EMIT      = 15'b100000000000000
    } state_t;

    typedef struct packed {
        logic             accept;
        logic             clr_wr;
        logic             ld_rd;
        logic             ld_wr;
        logic             pass_rd;
        logic             clust_start;
        logic             init_start;
        logic             init_wr;
        logic             acc_clear;
        logic             mean_start;
        logic             mean_wr;
        logic             iter_end;
        logic             clamp;
        logic             emit;
        logic             classify;
        logic [LVL_W-1:0] addr;
        logic [CLS_W-1:0] idx;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic cnt_zero;
        logic idx_last;
        logic stop;
        logic out_free;
        logic item_last;
    } status_t;

    // nearest mean to level x (8.8), lowest index on ties
    function automatic logic [CLS_W-1:0] nearest_class(
        input logic [OUT_W-1:0]   x,
        input mean_arr_t          m,
        input logic [LABEL_W-1:0] k
    );
        logic signed [MEAN_W:0] d;
        logic [MEAN_W:0]        ad;
        logic [MEAN_W:0]        bestd;
        logic [CLS_W-1:0]       best;
        best  = '0;
        bestd = '0;
        for (int j = 0; j < MAX_CLASSES; j++) begin
            d  = $signed({3'b000, x}) - $signed({m[j][MEAN_W-1], m[j]});
            ad = (d < 0) ? 19'(-d) : 19'(d);
            if (j == 0) begin
                best  = '0;
                bestd = ad;
            end else if ((LABEL_W'(j) < k) && (ad < bestd)) begin
                best  = CLS_W'(j);
                bestd = ad;
            end
        end
        return best;
    endfunction

endpackage

// File: rtl/core/histogram_kmeans_segmenter.sv
// ----------------------------------------------------------------------------
// histogram_kmeans_segmenter
// Gray-level histogram k-means: loads a histogram, clusters it, emits the
// means and labels pixels by nearest mean.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  s_      | in  | s_tvalid / s_tready  | tdata pixel, tuser cmd, tlast last
//  m_      | out | m_tvalid / m_tready  | tdata label/mean/converged, tuser kind,
//          |     |                      | tlast end_of_run
//  cfg_    | in  | cfg_valid / cfg_ready| cfg_index register, cfg_data value
//
// a load beat passes IDLE, LD_RD and LD_WR (read-modify-write of the histogram
// memory port), a classify beat IDLE and CLS plus any wait on m_tready.
// clustering after the last load beat: one divide per class for the initial
// centroids, then per pass a sweep over the bins, one divide per non-empty
// cluster (empty ones skip it) and a check, then a clamp, k emit beats and a
// clear sweep of the histogram.
// after reset the same clear sweep runs before the first beat is taken;
// config writes are always accepted. m_tready low holds the result beat and
// stalls the controller only when a new result is due.
module histogram_kmeans_segmenter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] pixel
    input  logic        s_tuser,    // [0] cmd
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [3:0] class_label, [19:4] mean_value,
                                    // [20] converged, [23:21] zero
    output logic        m_tuser,    // [0] result_kind
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import hkm_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    hkm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hkm_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// File: rtl/core/hkm_ram.sv
// ----------------------------------------------------------------------------
// hkm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module hkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/hkm_div.sv
// ----------------------------------------------------------------------------
// hkm_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hkm_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [hkm_pkg::DVD_W-1:0] dividend,
    input  logic [hkm_pkg::DVS_W-1:0] divisor,
    output logic                     done,
    output logic [hkm_pkg::DVD_W-1:0] quotient
);
    import hkm_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVS_W-1:0]  rem_reg;
    logic [DVS_W-1:0]  dvs_reg;
    logic [DVD_W-1:0]  quo_reg;
    logic [DVS_W:0]    rem_sh;
    logic              ge;

    assign rem_sh = {rem_reg, quo_reg[DVD_W-1]};
    assign ge     = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            quo_reg <= dividend;
        end else if (busy_reg) begin
            rem_reg <= ge ? DVS_W'(rem_sh - {1'b0, dvs_reg}) : rem_sh[DVS_W-1:0];
            quo_reg <= {quo_reg[DVD_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// File: rtl/core/hkm_dp.sv
// ----------------------------------------------------------------------------
// hkm_dp
// Datapath: histogram memory, cluster pass pipeline, accumulators, means,
// divider and output register.
// ----------------------------------------------------------------------------
module hkm_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  hkm_pkg::cmd_t          cmd,
    output hkm_pkg::status_t       status,
    input  logic [7:0]             s_tdata,
    input  logic                   s_tlast,
    input  logic                   cfg_valid,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);
    import hkm_pkg::*;

    logic [LABEL_W-1:0] num_classes_reg;
    logic [7:0]         max_iter_reg;
    logic [LABEL_W-1:0] k_act;
    logic [8:0]         cap;

    logic [LVL_W-1:0] item_pix_reg;
    logic             item_last_reg;
    logic [LVL_W-1:0] lvl_min_reg;
    logic [LVL_W-1:0] lvl_max_reg;

    mean_arr_t        means_reg;
    logic [7:0]       iter_reg;
    logic             conv_reg;
    logic             changed_reg;

    logic [SUM_W-1:0] wsum_reg [MAX_CLASSES];
    logic [TOT_W-1:0] tot_reg  [MAX_CLASSES];

    logic                   p1_valid_reg;
    logic [LVL_W-1:0]       p1_lvl_reg;
    logic                   p2_valid_reg;
    logic [CLS_W-1:0]       p2_cls_reg;
    logic [31:0]            p2_prod_reg;
    logic [COUNT_WIDTH-1:0] p2_cnt_reg;

    logic               out_valid_reg;
    logic               out_kind_reg;
    logic [LABEL_W-1:0] out_label_reg;
    logic [OUT_W-1:0]   out_mean_reg;
    logic               out_conv_reg;
    logic               out_last_reg;

    // histogram memory
    logic                   ram_we;
    logic [LVL_W-1:0]       ram_waddr;
    logic [COUNT_WIDTH-1:0] ram_wdata;
    logic [LVL_W-1:0]       ram_raddr;
    logic [COUNT_WIDTH-1:0] ram_rdata;
    logic [COUNT_WIDTH-1:0] bin_inc;

    assign bin_inc   = (ram_rdata == {COUNT_WIDTH{1'b1}}) ? ram_rdata : ram_rdata + 1'b1;
    assign ram_we    = cmd.clr_wr | cmd.ld_wr;
    assign ram_waddr = cmd.ld_wr ? item_pix_reg : cmd.addr;
    assign ram_wdata = cmd.ld_wr ? bin_inc : '0;
    assign ram_raddr = cmd.ld_rd ? item_pix_reg : cmd.addr;

    hkm_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (LEVELS)
    ) u_hist (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration
    assign k_act = (num_classes_reg == '0) ? LABEL_W'(1) :
                   (num_classes_reg > LABEL_W'(MAX_CLASSES)) ? LABEL_W'(MAX_CLASSES) :
                   num_classes_reg;
    assign cap   = (max_iter_reg == '0) ? 9'd1 : {1'b0, max_iter_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_classes_reg <= LABEL_W'(2);
            max_iter_reg    <= 8'd64;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_NUM_CLASSES: num_classes_reg <= cfg_data[LABEL_W-1:0];
                CFG_MAX_ITER:    max_iter_reg    <= cfg_data;
                default:         max_iter_reg    <= max_iter_reg;
            endcase
        end
    end

    // input beat and level range
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_pix_reg  <= s_tdata;
            item_last_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_wr) begin
            lvl_min_reg <= LVL_W'(LEVELS - 1);
            lvl_max_reg <= '0;
        end else if (cmd.ld_wr) begin
            if (item_pix_reg < lvl_min_reg) lvl_min_reg <= item_pix_reg;
            if (item_pix_reg > lvl_max_reg) lvl_max_reg <= item_pix_reg;
        end
    end

    // pass pipeline: read bin, pick cluster, accumulate
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= cmd.pass_rd;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_lvl_reg  <= cmd.addr;
        p2_cls_reg  <= nearest_class({p1_lvl_reg, 8'h00}, means_reg, k_act);
        p2_prod_reg <= 32'(ram_rdata) * 32'(p1_lvl_reg);
        p2_cnt_reg  <= ram_rdata;
    end

    logic [CLS_W-1:0] acc_idx;
    logic [SUM_W-1:0] wsum_rd;
    logic [TOT_W-1:0] tot_rd;

    assign acc_idx = p2_valid_reg ? p2_cls_reg : cmd.idx;
    assign wsum_rd = wsum_reg[acc_idx];
    assign tot_rd  = tot_reg[acc_idx];

    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                wsum_reg[i] <= '0;
                tot_reg[i]  <= '0;
            end
        end else if (p2_valid_reg) begin
            wsum_reg[p2_cls_reg] <= wsum_rd + SUM_W'(p2_prod_reg);
            tot_reg[p2_cls_reg]  <= tot_rd + TOT_W'(p2_cnt_reg);
        end
    end

    // shared divider: initial centroids and recomputed means
    logic [LABEL_W-1:0] idx_p1;
    logic [8:0]         span;
    logic [12:0]        ispan;
    logic [DVD_W-1:0]   div_dvd;
    logic [DVS_W-1:0]   div_dvs;
    logic               div_done;
    logic [DVD_W-1:0]   div_quo;

    assign idx_p1  = {1'b0, cmd.idx} + 1'b1;
    assign span    = {1'b0, lvl_max_reg} - {1'b0, lvl_min_reg} + 9'd2;
    assign ispan   = 13'(idx_p1) * 13'(span);
    assign div_dvd = cmd.mean_start ? ({wsum_rd, 9'b0} + DVD_W'(tot_rd))
                                    : DVD_W'({ispan, 9'b0});
    assign div_dvs = cmd.mean_start ? {tot_rd, 1'b0}
                                    : DVS_W'({1'b0, k_act} + 5'd1);

    hkm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.init_start | cmd.mean_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quo)
    );

    logic [22:0]              q_round;
    logic signed [MEAN_W:0]   init_sum;
    logic [MEAN_W-1:0]        init_val;
    logic [MEAN_W-1:0]        new_mean;

    // round half up, then move from the shifted domain back to original levels
    assign q_round  = {1'b0, div_quo[21:0]} + 23'd1;
    assign init_sum = $signed({1'b0, q_round[MEAN_W:1]}) +
                      $signed({3'b000, lvl_min_reg, 8'h00}) - 19'sd256;
    assign init_val = init_sum[MEAN_W-1:0];
    assign new_mean = {1'b0, div_quo[16:0]};

    // means and iteration state
    logic [CLS_W-1:0]  cls_px;
    logic [CLS_W-1:0]  mean_sel;
    logic [MEAN_W-1:0] mean_rd;

    assign cls_px   = nearest_class({item_pix_reg, 8'h00}, means_reg, k_act);
    assign mean_sel = cmd.classify ? cls_px : cmd.idx;
    assign mean_rd  = means_reg[mean_sel];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            means_reg <= '0;
        end else if (cmd.init_wr) begin
            means_reg[cmd.idx] <= init_val;
        end else if (cmd.mean_wr) begin
            means_reg[cmd.idx] <= new_mean;
        end else if (cmd.clamp) begin
            for (int i = 0; i < MAX_CLASSES; i++) begin
                if (LABEL_W'(i) < k_act) begin
                    if ($signed(means_reg[i]) < 0) begin
                        means_reg[i] <= '0;
                    end else if ($signed(means_reg[i]) > 18'sd65535) begin
                        means_reg[i] <= MEAN_W'(65535);
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_reg    <= '0;
            conv_reg    <= 1'b0;
            changed_reg <= 1'b0;
        end else begin
            if (cmd.clust_start) begin
                iter_reg <= '0;
                conv_reg <= 1'b0;
            end else if (cmd.iter_end) begin
                iter_reg <= iter_reg + 1'b1;
                conv_reg <= !changed_reg;
            end
            if (cmd.acc_clear) begin
                changed_reg <= 1'b0;
            end else if (cmd.mean_wr && (new_mean != means_reg[cmd.idx])) begin
                changed_reg <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit || cmd.classify) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit || cmd.classify) begin
            out_kind_reg  <= cmd.classify ? KIND_LABEL : KIND_MEAN;
            out_label_reg <= {1'b0, mean_sel} + 1'b1;
            out_mean_reg  <= mean_rd[OUT_W-1:0];
            out_conv_reg  <= conv_reg;
            out_last_reg  <= cmd.classify | status.idx_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_conv_reg, out_mean_reg, out_label_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    assign status.div_done  = div_done;
    assign status.cnt_zero  = (tot_rd == '0);
    assign status.idx_last  = ({1'b0, cmd.idx} == (k_act - 1'b1));
    assign status.stop      = !changed_reg || (({1'b0, iter_reg} + 9'd1) >= cap);
    assign status.out_free  = !out_valid_reg || m_tready;
    assign status.item_last = item_last_reg;

endmodule

// File: rtl/core/hkm_ctrl.sv
// ----------------------------------------------------------------------------
// hkm_ctrl
// Controller: sequences load, classify, clustering, emit and clear sweeps.
// ----------------------------------------------------------------------------
module hkm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tuser,
    output logic               s_tready,
    input  hkm_pkg::status_t   status,
    output hkm_pkg::cmd_t      cmd
);
    import hkm_pkg::*;

    state_t           state_reg, state_next;
    logic [LVL_W-1:0] v_reg, v_next;
    logic [CLS_W-1:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            v_reg     <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            v_reg     <= v_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        v_next     = v_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        cmd.addr   = v_reg;
        cmd.idx    = idx_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLR: begin
                cmd.clr_wr = 1'b1;
                v_next     = v_reg + 1'b1;
                if (v_reg == LVL_W'(LEVELS - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_tuser == CMD_CLASSIFY) ? ST_CLS : ST_LD_RD;
                end
            end
            ST_LD_RD: begin
                cmd.ld_rd  = 1'b1;
                state_next = ST_LD_WR;
            end
            ST_LD_WR: begin
                cmd.ld_wr = 1'b1;
                if (status.item_last) begin
                    cmd.clust_start = 1'b1;
                    idx_next        = '0;
                    state_next      = ST_INIT_GO;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_INIT_GO: begin
                cmd.init_start = 1'b1;
                state_next     = ST_INIT_WAIT;
            end
            ST_INIT_WAIT: begin
                if (status.div_done) begin
                    cmd.init_wr = 1'b1;
                    if (status.idx_last) begin
                        state_next = ST_ITER;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_INIT_GO;
                    end
                end
            end
            ST_ITER: begin
                cmd.acc_clear = 1'b1;
                v_next        = '0;
                state_next    = ST_PASS;
            end
            ST_PASS: begin
                cmd.pass_rd = 1'b1;
                v_next      = v_reg + 1'b1;
                if (v_reg == LVL_W'(LEVELS - 1)) state_next = ST_DRAIN;
            end
            ST_DRAIN: begin
                // wait for the last bins to pass the p1 and p2 registers into the accumulators
                v_next = v_reg + 1'b1;
                if (v_reg == LVL_W'(1)) begin
                    idx_next   = '0;
                    state_next = ST_RECALC;
                end
            end
            ST_RECALC: begin
                if (status.cnt_zero) begin
                    // empty cluster keeps its mean
                    if (status.idx_last) begin
                        state_next = ST_CHECK;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end else begin
                    cmd.mean_start = 1'b1;
                    state_next     = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (status.div_done) begin
                    cmd.mean_wr = 1'b1;
                    if (status.idx_last) begin
                        state_next = ST_CHECK;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RECALC;
                    end
                end
            end
            ST_CHECK: begin
                cmd.iter_end = 1'b1;
                state_next   = status.stop ? ST_CLAMP : ST_ITER;
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                idx_next   = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.idx_last) begin
                        v_next     = '0;
                        state_next = ST_CLR;
                    end else begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_CLS: begin
                if (status.out_free) begin
                    cmd.classify = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                v_next     = '0;
                state_next = ST_CLR;
            end
        endcase
    end

endmodule

// File: rtl/core/hkm_chk.sv
// ----------------------------------------------------------------------------
// hkm_chk
// Port-level checker for the segmenter, bound to the top level.
// ----------------------------------------------------------------------------
module hkm_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        s_tlast,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_index,
    input logic [7:0]  cfg_data
);
    import hkm_pkg::*;

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed under stall");

    // a label beat is always a one-beat run
    a_label_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_LABEL) |-> m_tlast)
        else $error("label beat without end of run");

    // labels are 1-based and at most MAX_CLASSES
    a_label_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3:0] != 4'd0) && (m_tdata[3:0] <= 4'(MAX_CLASSES)))
        else $error("label out of range");

    // no input beat taken while a mean run is still being delivered
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_MEAN) && !m_tlast |-> !s_tready)
        else $error("input taken during mean run");

endmodule

bind histogram_kmeans_segmenter hkm_chk u_hkm_chk (.*);
